// ===== rtl/rlfb_pkg.sv =====
// Shared constants and request payload types for the radio link frame builder.
`timescale 1ns / 1ps

package rlfb_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] END_BYTE   = 8'hEF;
    localparam logic [8:0] SUM_MOD    = 9'd255;

    typedef struct packed {
        logic [7:0] src_addr;
        logic [7:0] dst_addr;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } msg_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } frame_item_t;

endpackage

// ===== rtl/rlfb_stream_if.sv =====
// Valid/ready stream interface that carries one request payload.
`timescale 1ns / 1ps

interface rlfb_stream_if #(
    parameter type item_t = logic [7:0]
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/radio_link_frame_builder.sv =====
// Top level of the radio link frame builder: message bytes in, framed bytes out.
`timescale 1ns / 1ps

// Each msg request carries one payload byte; the first request of a frame also
// supplies sender, receiver and length, which are ignored on later requests. The
// block emits 0xFF, sender, receiver, length, then the payload byte; after the
// (length+1)-th payload byte it emits the mod-255 checksum and the terminator
// 0xEF flagged with frame_end. Bytes leave through a single output register,
// one per cycle unless frame.ready stalls it, so a request emits one byte
// mid-frame, five on the first payload byte, three on the last, and seven for
// a one-byte frame. A new request is taken in the same cycle the previous one
// releases its last byte; request data passes item_reg, then the output register.
module radio_link_frame_builder (
    input  logic          clk,
    input  logic          rst_n,
    rlfb_stream_if.sink   msg,
    rlfb_stream_if.source frame
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_SND   = 3'd1;
    localparam logic [2:0] PH_RCV   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SUM   = 3'd5;
    localparam logic [2:0] PH_END   = 3'd6;

    rlfb_pkg::msg_item_t   item_reg;
    logic                  item_valid_reg, item_valid_next;
    logic [2:0]            phase_reg, phase_next;
    logic [8:0]            bytes_left_reg, bytes_left_next;
    logic [7:0]            sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;
    rlfb_pkg::frame_item_t out_reg;

    logic       advance;
    logic       emit;
    logic       accept;
    logic       item_done;
    logic [7:0] cur_byte;
    logic       cur_end;
    logic [8:0] sum_add;
    logic [7:0] sum_mod;
    logic [8:0] bl_dec;
    logic [2:0] ph_cand;
    logic [8:0] bl_cand;
    logic [7:0] sum_cand;

    assign advance = !out_valid_reg || frame.ready;
    assign emit    = item_valid_reg && advance;
    assign sum_add = {1'b0, sum_reg} + {1'b0, cur_byte};
    assign sum_mod = (sum_add >= rlfb_pkg::SUM_MOD) ? 8'(sum_add - rlfb_pkg::SUM_MOD)
                                                     : sum_add[7:0];
    assign bl_dec  = bytes_left_reg - 9'd1;

    always_comb
    begin
        cur_byte  = 8'd0;
        cur_end   = 1'b0;
        item_done = 1'b0;
        ph_cand   = phase_reg;
        bl_cand   = bytes_left_reg;
        sum_cand  = sum_reg;
        unique case (phase_reg)
            PH_START:
            begin
                cur_byte = rlfb_pkg::START_BYTE;
                sum_cand = 8'd0;
                ph_cand  = PH_SND;
            end
            PH_SND:
            begin
                cur_byte = item_reg.src_addr;
                sum_cand = sum_mod;
                ph_cand  = PH_RCV;
            end
            PH_RCV:
            begin
                cur_byte = item_reg.dst_addr;
                sum_cand = sum_mod;
                ph_cand  = PH_LEN;
            end
            PH_LEN:
            begin
                cur_byte = item_reg.payload_length;
                sum_cand = sum_mod;
                bl_cand  = {1'b0, item_reg.payload_length} + 9'd1;
                ph_cand  = PH_DATA;
            end
            PH_DATA:
            begin
                cur_byte = item_reg.data_byte;
                sum_cand = sum_mod;
                bl_cand  = bl_dec;
                if (bl_dec == 9'd0)
                begin
                    ph_cand = PH_SUM;
                end
                else
                begin
                    item_done = 1'b1;
                end
            end
            PH_SUM:
            begin
                cur_byte = sum_reg;
                ph_cand  = PH_END;
            end
            PH_END:
            begin
                cur_byte  = rlfb_pkg::END_BYTE;
                cur_end   = 1'b1;
                sum_cand  = 8'd0;
                ph_cand   = PH_START;
                item_done = 1'b1;
            end
            default:
            begin
                ph_cand   = PH_START;
                item_done = 1'b1;
            end
        endcase
    end

    assign msg.ready = !item_valid_reg || (emit && item_done);
    assign accept    = msg.valid && msg.ready;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        if (emit)
        begin
            phase_next      = ph_cand;
            bytes_left_next = bl_cand;
            sum_next        = sum_cand;
        end

        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (emit && item_done)
        begin
            item_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_START;
            bytes_left_reg <= 9'd0;
            sum_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= msg.data;
        end
        if (emit)
        begin
            out_reg.out_byte  <= cur_byte;
            out_reg.frame_end <= cur_end;
        end
    end

    assign frame.valid = out_valid_reg;
    assign frame.data  = out_reg;

endmodule

// ===== rtl/rlfb_checker.sv =====
// Port-level checks for the radio link frame builder, bound to the top level.
`timescale 1ns / 1ps

module rlfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_ready,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] frame_byte,
    input logic       frame_end
);

    // hold a stalled output request
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=>
            frame_valid && $stable(frame_byte) && $stable(frame_end))
        else $error("stalled frame request changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_end |-> frame_byte == rlfb_pkg::END_BYTE)
        else $error("frame_end on a byte other than the terminator");

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready && frame_end |=>
            !frame_valid || frame_byte == rlfb_pkg::START_BYTE)
        else $error("byte after terminator is not a start byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready |-> ##2 frame_valid)
        else $error("accepted message produced no output byte");

endmodule

bind radio_link_frame_builder rlfb_checker u_rlfb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .msg_valid   (msg.valid),
    .msg_ready   (msg.ready),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.data.out_byte),
    .frame_end   (frame.data.frame_end)
);
